/* src/tcw_pkg.sv */
package tcw_pkg;

   // Default screen geometry.
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // Request type codes.
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Character codes with special handling.
   localparam logic [7:0] CH_NEWLINE         = 8'h0A;
   localparam logic [7:0] CH_BACKSPACE       = 8'h08;
   localparam logic [7:0] CH_FIRST_PRINTABLE = 8'h20;

   // Cell contents: attribute in the high byte, character in the low byte.
   localparam logic [7:0]  ATTR_GREY  = 8'h07;
   localparam logic [15:0] BLANK_CELL = 16'h0720;

   // Command from the request side to the cursor unit.
   typedef struct packed {
      logic       put;
      logic       home;
      logic [7:0] char_code;
   } cur_cmd_type;

endpackage

/* src/tcw_cursor.sv */
module tcw_cursor
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS,
   localparam int CW = $clog2(COLUMNS),
   localparam int RW = $clog2(ROWS),
   localparam int AW = $clog2(COLUMNS * ROWS)
) (
   input  logic          clock,
   input  logic          reset,
   input  cur_cmd_type   cmd,
   output logic [CW-1:0] col,
   output logic [RW-1:0] row,
   output logic [AW-1:0] cell_addr,
   output logic          wr_cell,
   output logic          scroll
);

   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [RW:0]   ROW_END  = (RW + 1)'(ROWS);
   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW:0]   row_nx;
   logic          printable;

   assign printable = cmd.char_code >= CH_FIRST_PRINTABLE;

   // The cell under the cursor, where a printable character lands.
   assign cell_addr = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign wr_cell   = cmd.put && printable;

   // Next cursor position for a put; the row may run one past the screen.
   always_comb begin
      col_in = col_ff;
      row_nx = {1'b0, row_ff};
      if (cmd.char_code == CH_NEWLINE) begin
         col_in = '0;
         row_nx = {1'b0, row_ff} + 1'b1;
      end else if (cmd.char_code == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            col_in = col_ff - 1'b1;
         end
      end else if (printable) begin
         if (col_ff == LAST_COL) begin
            col_in = '0;
            row_nx = {1'b0, row_ff} + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // A row past the bottom means the screen scrolls and the cursor stays on the last row.
   assign scroll = cmd.put && (row_nx == ROW_END);
   assign row_in = (row_nx == ROW_END) ? LAST_ROW : row_nx[RW-1:0];

   always_ff @(posedge clock) begin
      if (reset || cmd.home) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.put) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col = col_ff;
   assign row = row_ff;

endmodule

/* src/text_console_char_writer.sv */
// Text console character writer.
// Requests arrive on the req_ channel (valid/stall); each accepted word gives
// exactly one result word on the rsp_ channel, in order. A put writes a
// printable character with attribute 0x07 at the cursor and moves the cursor;
// newline and backspace only move it. A clear blanks the screen and homes the
// cursor; a read returns one cell. Every result reports the cursor.
// Put, read and unused request types go from idle to the finish step, which
// loads the result register, and back to idle. A clear, or a put that scrolls,
// runs one sweep over the whole screen memory, one cell per cycle through its
// single read and write port, before its finish step.
// One request is in work at a time; req_stall is high until it is finished.
// A new request is taken while the previous result still waits in the output
// register, but its result waits until that register is free.
// After reset the cursor is at home and a clearing pass blanks all COLUMNS*ROWS
// cells, during which no request is accepted.
// While rsp_stall is high the result word holds steady and the block stops
// after at most one more accepted request.
module text_console_char_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_cell_value,
   output logic        rsp_scrolled
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);
   localparam int AW = $clog2(CELL_COUNT);
   localparam int SW = $clog2(CELL_COUNT + 1);

   localparam logic [SW-1:0] SWEEP_END  = SW'(CELL_COUNT);
   localparam logic [SW-1:0] COPY_END   = SW'(COPY_COUNT);
   localparam logic [SW-1:0] ROW_STRIDE = SW'(COLUMNS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SWEEP  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic          copy_ff, copy_in;
   logic          report_ff, report_in;
   logic          stage_vld_ff, stage_vld_in;
   logic [AW-1:0] stage_addr_ff, stage_addr_in;
   logic          stage_copy_ff, stage_copy_in;
   logic          res_scroll_ff, res_scroll_in;
   logic          res_read_ff, res_read_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic [6:0]    rsp_col_ff;
   logic [4:0]    rsp_row_ff;
   logic [15:0]   rsp_cell_ff;
   logic          rsp_scrolled_ff;

   logic          accept;
   logic          read_ok;
   cur_cmd_type   cur_cmd;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [AW-1:0] cur_addr;
   logic          cur_wr_cell;
   logic          cur_scroll;

   logic [15:0]   mem [CELL_COUNT];
   logic [15:0]   rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;

   // Request handshake.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign read_ok   = (32'(req_cell_index) < CELL_COUNT);

   // Cursor unit.
   assign cur_cmd.put       = accept && (req_type == REQ_PUT);
   assign cur_cmd.home      = accept && (req_type == REQ_CLEAR);
   assign cur_cmd.char_code = req_char_code;

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cur_cmd),
      .col       (cur_col),
      .row       (cur_row),
      .cell_addr (cur_addr),
      .wr_cell   (cur_wr_cell),
      .scroll    (cur_scroll)
   );

   // Memory write port: the sweep stage has it during a sweep, a put otherwise.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = {ATTR_GREY, req_char_code};
      if (stage_vld_ff) begin
         mem_we    = 1'b1;
         mem_waddr = stage_addr_ff;
         mem_wdata = stage_copy_ff ? rd_data_ff : BLANK_CELL;
      end else if (cur_wr_cell) begin
         mem_we = 1'b1;
      end
   end

   // Memory read port: one row down during a scroll, the requested cell on a read.
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = AW'(req_cell_index);
      if (state_ff == ST_SWEEP) begin
         mem_raddr = AW'(sweep_ff + ROW_STRIDE);
         mem_re    = copy_ff && (sweep_ff < COPY_END);
      end else begin
         mem_re = accept && (req_type == REQ_READ) && read_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Sequencer: idle, sweep over the screen, finish into the result register.
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      copy_in       = copy_ff;
      report_in     = report_ff;
      stage_vld_in  = 1'b0;
      stage_addr_in = AW'(sweep_ff);
      stage_copy_in = copy_ff && (sweep_ff < COPY_END);
      res_scroll_in = res_scroll_ff;
      res_read_in   = res_read_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_scroll_in = 1'b0;
               res_read_in   = 1'b0;
               sweep_in      = '0;
               report_in     = 1'b1;
               state_in      = ST_FINISH;
               case (req_type)
                  REQ_PUT: begin
                     res_scroll_in = cur_scroll;
                     if (cur_scroll) begin
                        copy_in  = 1'b1;
                        state_in = ST_SWEEP;
                     end
                  end
                  REQ_CLEAR: begin
                     copy_in  = 1'b0;
                     state_in = ST_SWEEP;
                  end
                  REQ_READ: begin
                     res_read_in = read_ok;
                  end
                  default: begin
                     res_read_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_ff != SWEEP_END) begin
               stage_vld_in = 1'b1;
               sweep_in     = sweep_ff + 1'b1;
            end else if (!stage_vld_ff) begin
               state_in = report_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Control state; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         copy_ff      <= 1'b0;
         report_ff    <= 1'b0;
         stage_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         copy_ff      <= copy_in;
         report_ff    <= report_in;
         stage_vld_ff <= stage_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      stage_addr_ff <= stage_addr_in;
      stage_copy_ff <= stage_copy_in;
      res_scroll_ff <= res_scroll_in;
      res_read_ff   <= res_read_in;
      if (rsp_load) begin
         rsp_col_ff      <= 7'(cur_col);
         rsp_row_ff      <= 5'(cur_row);
         rsp_cell_ff     <= res_read_ff ? rd_data_ff : 16'h0000;
         rsp_scrolled_ff <= res_scroll_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   // The cursor row stays on the screen whenever a request can be taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (32'(cur_row) < ROWS))
      else $error("cursor row off the screen while idle");

   // A scrolled result always leaves the cursor on the last row.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> (32'(rsp_row_ff) == ROWS - 1))
      else $error("scrolled result with cursor off the last row");

   // The sweep write stage has drained before a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !stage_vld_ff)
      else $error("sweep write pending while idle");

   // A new result word only comes out of the finish step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result word appeared outside the finish step");

endmodule
